@@ rtl/tbeq_pkg.sv @@
// Shared types and constants for the ten-band biquad equaliser with volume.
`default_nettype none
package tbeq_pkg;
  localparam int NumBands     = 10;
  localparam int NumChannels  = 2;
  localparam int CoefWidth    = 32;
  localparam int CoefFracBits = 26;
  localparam int CoefsPerBand = 5;

  typedef enum logic [1:0] {
    ActProcess = 2'd0,
    ActCoef    = 2'd1,
    ActClear   = 2'd2,
    ActNone    = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    CfgEqEnable = 2'd0,
    CfgBandMask = 2'd1,
    CfgVolume   = 2'd2
  } cfg_idx_e;

  typedef enum logic [3:0] {
    StIdle,
    StClear,
    StBand,
    StRead,
    StMac,
    StShift,
    StSat,
    StWrite,
    StVol,
    StVolSat,
    StOut
  } state_e;

  function automatic logic signed [15:0] clip16(input logic signed [47:0] v);
    if (v > 48'sd32767) return 16'sd32767;
    if (v < -48'sd32768) return -16'sd32768;
    return v[15:0];
  endfunction
endpackage
`default_nettype wire

@@ rtl/tbeq_mac.sv @@
// Shared signed multiply-accumulate unit for the biquad sections.
`default_nettype none
module tbeq_mac #(
  parameter int CoefWidth = tbeq_pkg::CoefWidth,
  parameter int AccWidth  = CoefWidth + 40
) (
  input  wire logic                        clk_i,
  input  wire logic                        clr_i,
  input  wire logic                        en_i,
  input  wire logic signed [CoefWidth-1:0] coef_i,
  input  wire logic signed [32:0]          data_i,
  output logic signed [AccWidth-1:0]       acc_o
);
  logic signed [CoefWidth+32:0] prod_q;
  logic                         prod_v_q;
  logic signed [AccWidth-1:0]   acc_q, acc_d;

  always_ff @(posedge clk_i) begin
    prod_q   <= coef_i * data_i;
    prod_v_q <= en_i;
    acc_q    <= acc_d;
  end

  always_comb begin
    acc_d = acc_q;
    if (clr_i) acc_d = '0;
    else if (prod_v_q)
      acc_d = acc_q + AccWidth'(prod_q);
  end

  assign acc_o = acc_q;
endmodule
`default_nettype wire

@@ rtl/ten_band_biquad_eq_volume.sv @@
// Top level: biquad equaliser cascade over coefficient and history memories, then volume.
// A clear sweeps all NumBands*NumChannels history entries. A sample runs each enabled band
// through reads, one MAC step per coefficient, a drain and a write-back, passes over each
// skipped band, then goes through volume and output; with eq off only volume and output run.
// One item at a time: the next request is taken the cycle after the result leaves.
// Reset: eq on, mask 0, volume unity; history swept to zero, all NumBands*NumChannels entries.
`default_nettype none
module ten_band_biquad_eq_volume #(
  parameter int NumBands     = tbeq_pkg::NumBands,
  parameter int NumChannels  = tbeq_pkg::NumChannels,
  parameter int CoefWidth    = tbeq_pkg::CoefWidth,
  parameter int CoefFracBits = tbeq_pkg::CoefFracBits
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire logic [1:0]         action_i,
  input  wire logic signed [15:0] sample_i,
  input  wire logic               channel_i,
  input  wire logic [3:0]         band_i,
  input  wire logic [2:0]         coef_select_i,
  input  wire logic signed [31:0] coef_value_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output logic signed [15:0]      sample_out_o,
  output logic                    channel_out_o,
  input  wire logic               cfg_valid_i,
  output logic                    cfg_ready_o,
  input  wire logic [1:0]         cfg_index_i,
  input  wire logic [15:0]        cfg_data_i
);
  localparam int Cpb      = tbeq_pkg::CoefsPerBand;
  localparam int CDepth   = NumBands * Cpb;
  localparam int CAw      = $clog2(CDepth);
  localparam int BW       = $clog2(NumBands + 1);
  localparam int ChW      = (NumChannels > 1) ? $clog2(NumChannels) : 1;
  localparam int HDepth   = NumBands * NumChannels;
  localparam int HAw      = (HDepth > 1) ? $clog2(HDepth) : 1;
  localparam int AccWidth = CoefWidth + 40;

  // registers
  logic        eq_en_q;
  logic [NumBands-1:0] mask_q;
  logic [15:0] vol_q;
  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      eq_en_q <= 1'b1;
      mask_q  <= '0;
      vol_q   <= 16'h8000;
    end else if (cfg_valid_i) begin
      unique case (tbeq_pkg::cfg_idx_e'(cfg_index_i))
        tbeq_pkg::CfgEqEnable: eq_en_q <= cfg_data_i[0];
        tbeq_pkg::CfgBandMask: mask_q  <= NumBands'({6'd0, cfg_data_i[9:0]});
        tbeq_pkg::CfgVolume:   vol_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  tbeq_pkg::state_e st_q, st_d;
  logic [BW-1:0]  band_q, band_d;
  logic [2:0]     k_q, k_d;
  logic [HAw-1:0] clr_q, clr_d;
  logic           ch_q;
  logic [ChW-1:0] hch_q;
  logic signed [15:0] s_q, s_d;
  logic signed [31:0] y_q, y_d;
  logic signed [31:0] vp_q;
  logic signed [15:0] out_q;

  // memories
  logic signed [CoefWidth-1:0] cmem [CDepth];
  logic signed [CoefWidth-1:0] crd_q;
  logic [CAw-1:0] craddr;
  logic [95:0] hist [HDepth];
  logic [95:0] hrd_q, hwd;
  logic [HAw-1:0] haddr;
  logic hwe;

  wire acc_in = in_valid_i && !in_stall_o;
  wire cwe = acc_in && action_i == tbeq_pkg::ActCoef && {1'b0, band_i} < 5'(NumBands)
             && coef_select_i < 3'(Cpb);
  wire [CAw-1:0] cwaddr = CAw'(band_i * Cpb + coef_select_i);

  always_ff @(posedge clk_i) begin
    if (cwe) cmem[cwaddr] <= CoefWidth'(coef_value_i);
    crd_q <= cmem[craddr];
    if (hwe) hist[haddr] <= hwd;
    hrd_q <= hist[haddr];
  end

  assign craddr = CAw'(band_q * Cpb + k_q);
  assign haddr  = (st_q == tbeq_pkg::StClear) ? clr_q
                  : HAw'(band_q * NumChannels + hch_q);

  // history fields: [95:80] x1, [79:64] x2, [63:32] y1, [31:0] y2
  logic signed [15:0] x1, x2;
  logic signed [31:0] y1, y2;
  assign x1 = hrd_q[95:80];
  assign x2 = hrd_q[79:64];
  assign y1 = hrd_q[63:32];
  assign y2 = hrd_q[31:0];

  logic signed [32:0] mdata;
  always_comb begin
    unique case (k_q)
      3'd1: mdata = 33'(s_q) <<< 8;
      3'd2: mdata = 33'(x1) <<< 8;
      3'd3: mdata = 33'(x2) <<< 8;
      3'd4: mdata = -33'(y1);
      default: mdata = -33'(y2);
    endcase
  end

  logic mac_clr, mac_en;
  logic signed [AccWidth-1:0] acc;
  logic signed [CoefWidth-1:0] macc;
  assign macc = crd_q;
  tbeq_mac #(.CoefWidth(CoefWidth), .AccWidth(AccWidth)) u_mac (
    .clk_i, .clr_i(mac_clr), .en_i(mac_en), .coef_i(macc), .data_i(mdata), .acc_o(acc)
  );

  logic signed [AccWidth-1:0] sh_q;
  logic [NumBands-1:0] m_sh;
  assign m_sh = mask_q >> band_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= tbeq_pkg::StClear;
      band_q <= '0; k_q <= '0; clr_q <= '0;
    end else begin
      st_q <= st_d; band_q <= band_d; k_q <= k_d; clr_q <= clr_d;
    end
  end
  always_ff @(posedge clk_i) begin
    s_q <= s_d; y_q <= y_d;
    sh_q <= acc >>> CoefFracBits;
    if (acc_in) begin
      ch_q <= channel_i;
      hch_q <= (NumChannels > 1) ? ChW'(channel_i) : '0;
    end
    vp_q <= s_q * $signed({1'b0, (vol_q > 16'h8000) ? 16'h8000 : vol_q});
    if (st_q == tbeq_pkg::StVolSat) out_q <= tbeq_pkg::clip16(48'(vp_q >>> 15));
  end

  always_comb begin
    st_d = st_q; band_d = band_q; k_d = k_q; clr_d = clr_q; s_d = s_q; y_d = y_q;
    unique case (st_q)
      tbeq_pkg::StIdle: if (acc_in) begin
        band_d = '0;
        s_d = sample_i;
        priority if (action_i == tbeq_pkg::ActClear) begin
          clr_d = '0; st_d = tbeq_pkg::StClear;
        end else if (action_i == tbeq_pkg::ActProcess)
          st_d = eq_en_q ? tbeq_pkg::StBand : tbeq_pkg::StVol;
        else st_d = tbeq_pkg::StIdle;
      end
      tbeq_pkg::StClear: begin
        clr_d = clr_q + 1'b1;
        if (clr_q == HAw'(HDepth - 1)) st_d = tbeq_pkg::StIdle;
      end
      tbeq_pkg::StBand: begin
        k_d = '0;
        priority if (band_q == BW'(NumBands)) st_d = tbeq_pkg::StVol;
        else if (m_sh[0]) st_d = tbeq_pkg::StRead;
        else band_d = band_q + 1'b1;
      end
      tbeq_pkg::StRead: begin
        k_d = k_q + 1'b1; st_d = tbeq_pkg::StMac; // coef 0 and history now in flight
      end
      tbeq_pkg::StMac: begin
        k_d = k_q + 1'b1;
        if (k_q == 3'(Cpb)) st_d = tbeq_pkg::StShift;
      end
      tbeq_pkg::StShift: st_d = tbeq_pkg::StSat; // product drains, then shift
      tbeq_pkg::StSat: st_d = tbeq_pkg::StWrite;
      tbeq_pkg::StWrite: begin
        priority if (sh_q > AccWidth'(64'sh7FFFFFFF)) y_d = 32'sh7FFFFFFF;
        else if (sh_q < -AccWidth'(64'sh80000000)) y_d = 32'sh80000000;
        else y_d = sh_q[31:0];
        s_d = tbeq_pkg::clip16(48'(y_d / 32'sd256));
        band_d = band_q + 1'b1;
        st_d = tbeq_pkg::StBand;
      end
      tbeq_pkg::StVol: st_d = tbeq_pkg::StVolSat;
      tbeq_pkg::StVolSat: st_d = tbeq_pkg::StOut;
      tbeq_pkg::StOut: if (!out_stall_i) st_d = tbeq_pkg::StIdle;
      default: st_d = tbeq_pkg::StIdle;
    endcase
  end

  always_comb begin
    mac_clr = (st_q == tbeq_pkg::StBand);
    mac_en  = (st_q == tbeq_pkg::StMac);
    hwe     = (st_q == tbeq_pkg::StClear) || (st_q == tbeq_pkg::StWrite);
    hwd     = (st_q == tbeq_pkg::StWrite) ? {s_q, x1, y_d, y1} : '0;
  end

  assign in_stall_o    = (st_q != tbeq_pkg::StIdle);
  assign out_valid_o   = (st_q == tbeq_pkg::StOut);
  assign sample_out_o  = out_q;
  assign channel_out_o = ch_q;
endmodule
`default_nettype wire
